FILE: sv/top_k_newest_message_select_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for top_k_newest_message_select_core
// Shared helpers that wrap concurrent assertions on the block clock.
// ----------------------------------------------------------------------------
`ifndef TOP_K_NEWEST_MESSAGE_SELECT_CORE_DEFINES_SVH
`define TOP_K_NEWEST_MESSAGE_SELECT_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TKNS_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TKNS_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/tkns_pkg.sv
// ----------------------------------------------------------------------------
// tkns_pkg
// Shared types and constants of the top-k newest message selector.
// ----------------------------------------------------------------------------
package tkns_pkg;

   localparam int KEEP_COUNT_DEF = 20;
   localparam int FIELD_W        = 63;
   localparam int RANK_W         = 6;

   // One kept message
   typedef struct packed {
      logic [FIELD_W-1:0] date;
      logic [FIELD_W-1:0] msg;
      logic [FIELD_W-1:0] author;
      logic               post;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic              accept;
      logic              insert;
      logic              pop;
      logic              out_last;
      logic [RANK_W-1:0] rank;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic s1_valid;
      logic s1_last;
      logic out_valid;
   } status_type;

endpackage

FILE: sv/tkns_datapath.sv
// ----------------------------------------------------------------------------
// tkns_datapath
// Input stage, sorted insertion cells, shift-out path and result register.
// ----------------------------------------------------------------------------
`include "top_k_newest_message_select_core_defines.svh"

module tkns_datapath #(
   parameter int KEEP_COUNT = tkns_pkg::KEEP_COUNT_DEF,
   parameter int CNT_W      = $clog2(KEEP_COUNT + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tkns_pkg::cmd_type            cmd_i,
   output tkns_pkg::status_type         status_o,
   output logic [CNT_W-1:0]             count_o,
   input  logic                         csr_write_en,
   input  logic [tkns_pkg::FIELD_W-1:0] csr_write_data,
   input  logic                         req_has_candidate,
   input  logic [tkns_pkg::FIELD_W-1:0] req_message_id,
   input  logic [tkns_pkg::FIELD_W-1:0] req_creation_date,
   input  logic [tkns_pkg::FIELD_W-1:0] req_author_id,
   input  logic                         req_is_post,
   input  logic                         req_last_item,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output logic                         rsp_valid_res,
   output logic [tkns_pkg::FIELD_W-1:0] rsp_out_author_id,
   output logic [tkns_pkg::FIELD_W-1:0] rsp_out_message_id,
   output logic [tkns_pkg::FIELD_W-1:0] rsp_out_creation_date,
   output logic                         rsp_out_is_post,
   output logic [tkns_pkg::RANK_W-1:0]  rsp_rank,
   output logic                         rsp_last_result
);

   logic [tkns_pkg::FIELD_W-1:0] max_date_ff;
   logic                         s1_valid_ff;
   logic                         s1_last_ff;
   logic                         s1_qual_ff;
   tkns_pkg::entry_type          cand_ff;
   tkns_pkg::entry_type          cand_in;
   tkns_pkg::entry_type          ent_ff [KEEP_COUNT];
   tkns_pkg::entry_type          ent_in [KEEP_COUNT];
   logic [KEEP_COUNT-1:0]        beat_w;
   logic [CNT_W-1:0]             count_ff;
   logic [CNT_W-1:0]             count_in;
   logic                         do_insert;
   logic                         out_valid_ff;
   logic                         out_valid_res_ff;
   tkns_pkg::entry_type          out_ent_ff;
   logic [tkns_pkg::RANK_W-1:0]  out_rank_ff;
   logic                         out_last_ff;

   assign do_insert = cmd_i.insert && s1_qual_ff;

   always_comb begin
      cand_in.date   = req_creation_date;
      cand_in.msg    = req_message_id;
      cand_in.author = req_author_id;
      cand_in.post   = req_is_post;
   end

   // Register and input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         max_date_ff <= {tkns_pkg::FIELD_W{1'b1}};
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            max_date_ff <= csr_write_data;
         end
         s1_valid_ff <= cmd_i.accept;
      end
      if (cmd_i.accept) begin
         cand_ff    <= cand_in;
         s1_last_ff <= req_last_item;
         s1_qual_ff <= req_has_candidate && (req_creation_date < max_date_ff);
      end
   end

   // Insertion cells: each compares the candidate against its own entry
   for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
      logic occupied;
      logic better;
      logic take_cand;

      assign occupied = CNT_W'(i) < count_ff;
      assign better   = (cand_ff.date != ent_ff[i].date) ?
                        (cand_ff.date > ent_ff[i].date) :
                        (cand_ff.msg < ent_ff[i].msg);
      assign beat_w[i] = !occupied || better;

      if (i == 0) begin : g_head
         assign take_cand = beat_w[i];
      end else begin : g_body
         assign take_cand = beat_w[i] && !beat_w[i-1];
      end

      always_comb begin
         ent_in[i] = ent_ff[i];
         if (do_insert) begin
            if (take_cand) begin
               ent_in[i] = cand_ff;
            end else if (beat_w[i]) begin
               if (i > 0) begin
                  ent_in[i] = ent_ff[(i > 0) ? i - 1 : 0];
               end
            end
         end else if (cmd_i.pop) begin
            if (i < KEEP_COUNT - 1) begin
               ent_in[i] = ent_ff[(i < KEEP_COUNT - 1) ? i + 1 : i];
            end
         end
      end

      always_ff @(posedge clock) begin
         ent_ff[i] <= ent_in[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd_i.pop && cmd_i.out_last) begin
         count_in = '0;
      end else if (do_insert && (count_ff < CNT_W'(KEEP_COUNT))) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd_i.pop) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (cmd_i.pop) begin
         if (count_ff == '0) begin
            out_valid_res_ff <= 1'b0;
            out_ent_ff       <= '0;
            out_rank_ff      <= '0;
         end else begin
            out_valid_res_ff <= 1'b1;
            out_ent_ff       <= ent_ff[0];
            out_rank_ff      <= cmd_i.rank;
         end
         out_last_ff <= cmd_i.out_last;
      end
   end

   assign status_o.s1_valid  = s1_valid_ff;
   assign status_o.s1_last   = s1_last_ff;
   assign status_o.out_valid = out_valid_ff;
   assign count_o            = count_ff;

   assign rsp_valid             = out_valid_ff;
   assign rsp_valid_res         = out_valid_res_ff;
   assign rsp_out_author_id     = out_ent_ff.author;
   assign rsp_out_message_id    = out_ent_ff.msg;
   assign rsp_out_creation_date = out_ent_ff.date;
   assign rsp_out_is_post       = out_ent_ff.post;
   assign rsp_rank              = out_rank_ff;
   assign rsp_last_result       = out_last_ff;

   `TKNS_ASSERT(a_count_reset, clock, reset |=> count_ff == '0, "count not cleared by reset")
   `TKNS_ASSERT_RST(a_count_bound, clock, reset, count_ff <= CNT_W'(KEEP_COUNT), "count overflow")
   `TKNS_ASSERT_RST(a_run_clear, clock, reset, cmd_i.pop && cmd_i.out_last |=> count_ff == '0, "count not cleared after final result")
   `TKNS_ASSERT_RST(a_pop_ready, clock, reset, cmd_i.pop |-> !out_valid_ff || !rsp_stall, "result overwritten while stalled")

endmodule

FILE: sv/tkns_ctrl.sv
// ----------------------------------------------------------------------------
// tkns_ctrl
// Run / emit sequencer of the top-k newest message selector.
// ----------------------------------------------------------------------------
`include "top_k_newest_message_select_core_defines.svh"

module tkns_ctrl #(
   parameter int KEEP_COUNT = tkns_pkg::KEEP_COUNT_DEF,
   parameter int CNT_W      = $clog2(KEEP_COUNT + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 rsp_stall,
   input  tkns_pkg::status_type status_i,
   input  logic [CNT_W-1:0]     count_i,
   output tkns_pkg::cmd_type    cmd_o
);

   typedef enum logic {
      S_RUN,
      S_EMIT
   } state_type;

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] rank_ff;
   logic [CNT_W-1:0] rank_in;
   logic             out_ready;
   logic             out_last;

   assign out_ready = !status_i.out_valid || !rsp_stall;
   assign out_last  = (count_i == '0) || ((rank_ff + CNT_W'(1)) == count_i);
   assign req_stall = (state_ff == S_EMIT) || (status_i.s1_valid && status_i.s1_last);

   always_comb begin
      state_in        = state_ff;
      rank_in         = rank_ff;
      cmd_o.accept    = req_valid && !req_stall;
      cmd_o.insert    = 1'b0;
      cmd_o.pop       = 1'b0;
      cmd_o.out_last  = out_last;
      cmd_o.rank      = tkns_pkg::RANK_W'(rank_ff);
      case (state_ff)
         S_RUN: begin
            cmd_o.insert = status_i.s1_valid;
            if (status_i.s1_valid && status_i.s1_last) begin
               state_in = S_EMIT;
               rank_in  = '0;
            end
         end
         S_EMIT: begin
            if (out_ready) begin
               cmd_o.pop = 1'b1;
               rank_in   = rank_ff + CNT_W'(1);
               if (out_last) begin
                  state_in = S_RUN;
               end
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RUN;
         rank_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rank_ff  <= rank_in;
      end
   end

   `TKNS_ASSERT_RST(a_pop_in_emit, clock, reset, cmd_o.pop |-> state_ff == S_EMIT, "pop outside emit")
   `TKNS_ASSERT_RST(a_no_accept_emit, clock, reset, state_ff == S_EMIT |-> !cmd_o.accept && !cmd_o.insert, "request taken during emit")

endmodule

FILE: sv/top_k_newest_message_select_core.sv
// ----------------------------------------------------------------------------
// top_k_newest_message_select_core
// Keeps the newest KEEP_COUNT messages dated before a cutoff and emits them
// ranked, newest first, when a request flagged last arrives.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): one request per cycle while req_stall is low.
//    A request with req_has_candidate set is kept if its date is below the
//    cutoff in csr_write_data (written with csr_write_en while idle).
//  - Requests are registered, then inserted in the following cycle into a
//    chain of compare cells that keeps the list sorted: one request per
//    cycle sustained while req_stall is low.
//  - A request with req_last_item set stalls the request channel; the list
//    is then shifted out of cell 0, one result per cycle unless rsp_stall
//    holds it, best first, with rsp_rank counting from 0 and rsp_last_result
//    on the final one. An empty run gives one result with rsp_valid_res low.
//  - rsp_stall holds the result register and pauses the shift-out; requests
//    are accepted again the cycle after the final result is loaded.
//  - Reset (synchronous) empties the list, sets the cutoff to all ones and
//    drops any result in flight.
// ----------------------------------------------------------------------------
module top_k_newest_message_select_core #(
   parameter int KEEP_COUNT = tkns_pkg::KEEP_COUNT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_write_en,
   input  logic [tkns_pkg::FIELD_W-1:0] csr_write_data,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_has_candidate,
   input  logic [tkns_pkg::FIELD_W-1:0] req_message_id,
   input  logic [tkns_pkg::FIELD_W-1:0] req_creation_date,
   input  logic [tkns_pkg::FIELD_W-1:0] req_author_id,
   input  logic                         req_is_post,
   input  logic                         req_last_item,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_valid_res,
   output logic [tkns_pkg::FIELD_W-1:0] rsp_out_author_id,
   output logic [tkns_pkg::FIELD_W-1:0] rsp_out_message_id,
   output logic [tkns_pkg::FIELD_W-1:0] rsp_out_creation_date,
   output logic                         rsp_out_is_post,
   output logic [tkns_pkg::RANK_W-1:0]  rsp_rank,
   output logic                         rsp_last_result
);

   localparam int CNT_W = $clog2(KEEP_COUNT + 1);

   tkns_pkg::cmd_type    cmd;
   tkns_pkg::status_type status;
   logic [CNT_W-1:0]     count;

   // Sequencer: run phase takes requests, emit phase drains the list
   tkns_ctrl #(
      .KEEP_COUNT (KEEP_COUNT),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .status_i  (status),
      .count_i   (count),
      .cmd_o     (cmd)
   );

   // Cutoff register, input stage, sorted cells and result register
   tkns_datapath #(
      .KEEP_COUNT (KEEP_COUNT),
      .CNT_W      (CNT_W)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd_i                 (cmd),
      .status_o              (status),
      .count_o               (count),
      .csr_write_en          (csr_write_en),
      .csr_write_data        (csr_write_data),
      .req_has_candidate     (req_has_candidate),
      .req_message_id        (req_message_id),
      .req_creation_date     (req_creation_date),
      .req_author_id         (req_author_id),
      .req_is_post           (req_is_post),
      .req_last_item         (req_last_item),
      .rsp_stall             (rsp_stall),
      .rsp_valid             (rsp_valid),
      .rsp_valid_res         (rsp_valid_res),
      .rsp_out_author_id     (rsp_out_author_id),
      .rsp_out_message_id    (rsp_out_message_id),
      .rsp_out_creation_date (rsp_out_creation_date),
      .rsp_out_is_post       (rsp_out_is_post),
      .rsp_rank              (rsp_rank),
      .rsp_last_result       (rsp_last_result)
   );

endmodule
